>>> rtl/ycbcr420_to_rgb5551_quad_macros.svh
// Assertion macros shared by the color converter RTL
`ifndef YCBCR420_TO_RGB5551_QUAD_MACROS_SVH
`define YCBCR420_TO_RGB5551_QUAD_MACROS_SVH
`ifndef NO_ASSERTIONS
`define YCQ_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define YCQ_ASSERT_RST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define YCQ_ASSERT(label, clk, rst, prop, msg)
`define YCQ_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

>>> rtl/ycq_pkg.sv
// Shared widths, constants and types of the YCbCr 4:2:0 to RGB5551 converter
package ycq_pkg;

   localparam int SAMPLE_W  = 8;
   localparam int TERM_W    = 15;   // chroma terms lie in 1952..30767
   localparam int SUM_W     = 16;   // Y*64 + term stays below 47088
   localparam int CHAN_W    = 5;
   localparam int PIXEL_W   = 16;
   localparam int LANES     = 4;
   localparam int PROD_W    = 18;

   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 64;

   localparam logic signed [PROD_W-1:0] COEF_R_CR   = 18'sd90;
   localparam logic signed [PROD_W-1:0] COEF_G_CB   = -18'sd22;
   localparam logic signed [PROD_W-1:0] COEF_G_CR   = -18'sd46;
   localparam logic signed [PROD_W-1:0] COEF_B_CB   = 18'sd113;
   localparam logic signed [PROD_W-1:0] CHROMA_BIAS = 18'sh4020;
   localparam logic [SAMPLE_W:0]        CHROMA_ZERO = 9'd128;

   typedef struct packed {
      logic [TERM_W-1:0] red;
      logic [TERM_W-1:0] green;
      logic [TERM_W-1:0] blue;
   } chroma_terms_type;

endpackage

>>> rtl/ycq_chroma.sv
// Chroma term stage: shared R, G and B offsets for one 2x2 group
module ycq_chroma
   import ycq_pkg::*;
(
   input  logic                  clock,
   input  logic                  enable,
   input  logic [SAMPLE_W-1:0]   chroma_blue,
   input  logic [SAMPLE_W-1:0]   chroma_red,
   output chroma_terms_type      terms
);

   logic signed [SAMPLE_W:0] cb_off;
   logic signed [SAMPLE_W:0] cr_off;
   logic signed [PROD_W-1:0] cb_ext;
   logic signed [PROD_W-1:0] cr_ext;
   logic signed [PROD_W-1:0] red_full;
   logic signed [PROD_W-1:0] green_full;
   logic signed [PROD_W-1:0] blue_full;
   chroma_terms_type         terms_ff;
   chroma_terms_type         terms_in;

   assign cb_off = $signed({1'b0, chroma_blue}) - $signed(CHROMA_ZERO);
   assign cr_off = $signed({1'b0, chroma_red}) - $signed(CHROMA_ZERO);
   assign cb_ext = {{(PROD_W-SAMPLE_W-1){cb_off[SAMPLE_W]}}, cb_off};
   assign cr_ext = {{(PROD_W-SAMPLE_W-1){cr_off[SAMPLE_W]}}, cr_off};

   assign red_full   = PROD_W'(cr_ext * COEF_R_CR + CHROMA_BIAS);
   assign green_full = PROD_W'(cb_ext * COEF_G_CB + cr_ext * COEF_G_CR + CHROMA_BIAS);
   assign blue_full  = PROD_W'(cb_ext * COEF_B_CB + CHROMA_BIAS);

   // all three terms are positive and fit the term width
   assign terms_in.red   = red_full[TERM_W-1:0];
   assign terms_in.green = green_full[TERM_W-1:0];
   assign terms_in.blue  = blue_full[TERM_W-1:0];

   always_ff @(posedge clock) begin
      if (enable) begin
         terms_ff <= terms_in;
      end
   end

   assign terms = terms_ff;

endmodule

>>> rtl/ycq_lane.sv
// Per-pixel lane: add luma to chroma terms, clamp and pack to RGB5551
module ycq_lane
   import ycq_pkg::*;
(
   input  logic                  clock,
   input  logic                  enable,
   input  logic [SAMPLE_W-1:0]   luma,
   input  chroma_terms_type      terms,
   output logic [PIXEL_W-1:0]    pixel
);

   logic [PIXEL_W-1:0] pixel_ff;
   logic [PIXEL_W-1:0] pixel_in;
   logic [CHAN_W-1:0]  red;
   logic [CHAN_W-1:0]  green;
   logic [CHAN_W-1:0]  blue;

   // level = (sum >> 6) - 256; below 0 clamps to 0, 256 and up saturates
   function automatic logic [CHAN_W-1:0] channel_bits(
      input logic [SAMPLE_W-1:0] y,
      input logic [TERM_W-1:0]   term
   );
      logic [SUM_W-1:0]  sum;
      logic [SUM_W-7:0]  level;
      logic [CHAN_W-1:0] bits;
      sum   = {2'b00, y, 6'b000000} + {1'b0, term};
      level = sum[SUM_W-1:6];
      if (level[9]) begin
         bits = '1;
      end else if (!level[8]) begin
         bits = '0;
      end else begin
         bits = level[7:3];
      end
      return bits;
   endfunction

   assign red      = channel_bits(luma, terms.red);
   assign green    = channel_bits(luma, terms.green);
   assign blue     = channel_bits(luma, terms.blue);
   assign pixel_in = {red, green, blue, 1'b0};

   always_ff @(posedge clock) begin
      if (enable) begin
         pixel_ff <= pixel_in;
      end
   end

   assign pixel = pixel_ff;

endmodule

>>> rtl/ycbcr420_to_rgb5551_quad.sv
// Top level: 4:2:0 YCbCr 2x2 group to four RGB5551 words, four parallel lanes
// Pipeline: an accepted req word is registered in the chroma stage, then the lane stage, before rsp_tvalid.
// Throughput: one word per cycle; the two-stage pipeline stalls only on rsp_tready.
// The chroma terms are computed once per group and fanned out to four pixel lanes.
// Reset (synchronous, active high) clears both stage valid flags; data regs hold.
`include "ycbcr420_to_rgb5551_quad_macros.svh"
module ycbcr420_to_rgb5551_quad
   import ycq_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // luma_top_left, luma_top_right, luma_bottom_left, luma_bottom_right,
   // chroma_blue, chroma_red (8 bits each, lowest first)
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // pixel_top_left, pixel_top_right, pixel_bottom_left, pixel_bottom_right
   // (16 bits each, lowest first)
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic                  stage1_valid_ff;
   logic                  stage1_valid_in;
   logic                  out_valid_ff;
   logic                  out_valid_in;
   logic                  advance;
   logic                  load;
   logic [SAMPLE_W-1:0]   luma_ff [LANES];
   chroma_terms_type      terms;
   logic [PIXEL_W-1:0]    pixels [LANES];

   assign advance    = !out_valid_ff || rsp_tready;
   assign load       = !stage1_valid_ff || advance;
   assign req_tready = load;

   assign stage1_valid_in = load ? req_tvalid : stage1_valid_ff;
   assign out_valid_in    = advance ? stage1_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage1_valid_ff <= 1'b0;
         out_valid_ff    <= 1'b0;
      end else begin
         stage1_valid_ff <= stage1_valid_in;
         out_valid_ff    <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         for (int i = 0; i < LANES; i++) begin
            luma_ff[i] <= req_tdata[i*SAMPLE_W +: SAMPLE_W];
         end
      end
   end

   ycq_chroma u_chroma (
      .clock       (clock),
      .enable      (load),
      .chroma_blue (req_tdata[LANES*SAMPLE_W +: SAMPLE_W]),
      .chroma_red  (req_tdata[(LANES+1)*SAMPLE_W +: SAMPLE_W]),
      .terms       (terms)
   );

   for (genvar g = 0; g < LANES; g++) begin : g_lane
      ycq_lane u_lane (
         .clock  (clock),
         .enable (advance),
         .luma   (luma_ff[g]),
         .terms  (terms),
         .pixel  (pixels[g])
      );
      assign rsp_tdata[g*PIXEL_W +: PIXEL_W] = pixels[g];
   end

   assign rsp_tvalid = out_valid_ff;

   `YCQ_ASSERT_RST(a_reset_clears_out, clock, reset |=> !out_valid_ff, "output valid after reset")
   `YCQ_ASSERT(a_accept_fills_stage1, clock, reset, req_tvalid && req_tready |=> stage1_valid_ff, "accepted word missing from stage 1")
   `YCQ_ASSERT(a_stage1_held, clock, reset, stage1_valid_ff && !advance |=> stage1_valid_ff, "stalled stage 1 word dropped")
   `YCQ_ASSERT(a_stage1_moves, clock, reset, stage1_valid_ff && advance |=> out_valid_ff, "stage 1 word lost on advance")
   `YCQ_ASSERT(a_pad_bits_clear, clock, reset, out_valid_ff |-> !rsp_tdata[0] && !rsp_tdata[16] && !rsp_tdata[32] && !rsp_tdata[48], "pixel pad bit set")

endmodule

>>> verif/ycbcr420_to_rgb5551_quad_tb.sv
// Self-checking stream testbench for the YCbCr 4:2:0 quad to RGB5551 converter
`timescale 1ns / 100ps
module ycbcr420_to_rgb5551_quad_tb;
   import ycq_pkg::*;

   localparam int CLOCK_HALF    = 10;
   localparam int RESET_CYCLES  = 12;
   localparam int RANDOM_GROUPS = 1550;
   localparam int CYCLE_LIMIT   = 300000;
   localparam int DRAIN_CYCLES  = 8;
   localparam int HOLD_AT       = 600;   // groups accepted before the long hold-off
   localparam int HOLD_LEN      = 250;
   localparam int MAX_REPORTS   = 20;

   // fixed-point color matrix, 1/64 units
   localparam int RED_PER_CR   = 90;
   localparam int GREEN_PER_CB = -22;
   localparam int GREEN_PER_CR = -46;
   localparam int BLUE_PER_CB  = 113;
   localparam int TERM_BIAS    = 'h4020;
   localparam int CHROMA_MID   = 128;
   localparam int LEVEL_OFFSET = 'h100;
   localparam logic [7:0] CHANNEL_SAT  = 8'hF8;
   localparam logic [7:0] CHANNEL_MASK = 8'hF8;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   logic [REQ_DATA_W-1:0] group_queue[$];
   logic [RSP_DATA_W-1:0] pending_pixels[$];
   int fail_count = 0;
   int accepted_groups = 0;
   int checked_words = 0;
   int cycle_count = 0;
   int sent_groups = 0;
   int send_gap = 0;
   int recv_gap = 0;
   int hold_left = 0;
   bit hold_done = 0;

   ycbcr420_to_rgb5551_quad dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #CLOCK_HALF clock = ~clock;
   end

   // clamp to 0..255 after removing the bias, keep the top five bits
   function automatic logic [7:0] clamp_top5(int sum);
      int level;
      level = (sum >>> 6) - LEVEL_OFFSET;
      if (level < 0) return 8'h00;
      if (level > 255) return CHANNEL_SAT;
      return level[7:0] & CHANNEL_MASK;
   endfunction

   function automatic logic [RSP_DATA_W-1:0] rgb_quad_of(logic [REQ_DATA_W-1:0] group);
      int cb, cr, red_term, green_term, blue_term, y64;
      logic [7:0] r, g, b;
      logic [RSP_DATA_W-1:0] quad;
      cb = int'(group[4*SAMPLE_W +: SAMPLE_W]) - CHROMA_MID;
      cr = int'(group[5*SAMPLE_W +: SAMPLE_W]) - CHROMA_MID;
      red_term   = RED_PER_CR * cr + TERM_BIAS;
      green_term = GREEN_PER_CB * cb + GREEN_PER_CR * cr + TERM_BIAS;
      blue_term  = BLUE_PER_CB * cb + TERM_BIAS;
      quad = '0;
      for (int k = 0; k < LANES; k++) begin
         y64 = int'(group[k*SAMPLE_W +: SAMPLE_W]) * 64;
         r = clamp_top5(y64 + red_term);
         g = clamp_top5(y64 + green_term);
         b = clamp_top5(y64 + blue_term);
         quad[k*PIXEL_W +: PIXEL_W] = {r[7:3], g[7:3], b[7:3], 1'b0};
      end
      return quad;
   endfunction

   function automatic logic [REQ_DATA_W-1:0] pack_group(logic [7:0] tl, logic [7:0] tr,
                                                       logic [7:0] bl, logic [7:0] br,
                                                       logic [7:0] cb, logic [7:0] cr);
      return {cr, cb, br, bl, tr, tl};
   endfunction

   // extremes half the time per field, otherwise uniform
   function automatic logic [7:0] edgy_sample();
      case ($urandom_range(0, 3))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic int idle_draw(bit enabled);
      if (!enabled) return 0;
      return $urandom_range(0, 15);
   endfunction

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (send_gap > 0) begin
            req_tvalid <= 1'b0;
            send_gap <= send_gap - 1;
         end else if (group_queue.size() > 0) begin
            req_tvalid <= 1'b1;
            req_tdata <= group_queue.pop_front();
            sent_groups <= sent_groups + 1;
            // sender idles on alternate stretches of 128 words
            send_gap <= idle_draw(sent_groups[7] && sent_groups > 25);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // long receiver hold-off, once, so the pipeline backs up into req_tready
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (!hold_done && accepted_groups >= HOLD_AT) begin
         hold_left <= HOLD_LEN;
         hold_done <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // receiver
   always @(posedge clock) begin
      int gap;
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_gap <= 0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
      end else if (rsp_tvalid && rsp_tready) begin
         gap = idle_draw((checked_words / 64) % 3 != 0);
         rsp_tready <= (gap == 0);
         recv_gap <= gap;
      end else if (recv_gap > 0) begin
         rsp_tready <= (recv_gap == 1);
         recv_gap <= recv_gap - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // monitor: predict on input accept, check on output accept
   always @(posedge clock) begin
      logic [RSP_DATA_W-1:0] want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            pending_pixels.push_back(rgb_quad_of(req_tdata));
            accepted_groups <= accepted_groups + 1;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pending_pixels.size() == 0) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("%0t: unexpected rsp word, expected none, got %h", $time, rsp_tdata);
            end else begin
               want = pending_pixels.pop_front();
               for (int k = 0; k < LANES; k++) begin
                  if (rsp_tdata[k*PIXEL_W +: PIXEL_W] !== want[k*PIXEL_W +: PIXEL_W]) begin
                     fail_count++;
                     if (fail_count <= MAX_REPORTS)
                        $display("%0t: word %0d pixel %0d mismatch, expected %h, got %h",
                                 $time, checked_words, k, want[k*PIXEL_W +: PIXEL_W],
                                 rsp_tdata[k*PIXEL_W +: PIXEL_W]);
                  end
               end
            end
            checked_words <= checked_words + 1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
                  pending_pixels.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      int pick;
      logic [7:0] cb, cr;

      // directed: extremes, neutral chroma, clamp edges, bit patterns
      group_queue.push_back(pack_group(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      group_queue.push_back(pack_group(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
      group_queue.push_back(pack_group(8'h00, 8'hFF, 8'h00, 8'hFF, 8'd128, 8'd128));
      group_queue.push_back(pack_group(8'd16, 8'd235, 8'd128, 8'd64, 8'd128, 8'd128));
      group_queue.push_back(pack_group(8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00));
      group_queue.push_back(pack_group(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF));
      group_queue.push_back(pack_group(8'h00, 8'hFF, 8'h80, 8'h40, 8'h00, 8'hFF));
      group_queue.push_back(pack_group(8'hFF, 8'h00, 8'h80, 8'hC0, 8'hFF, 8'h00));
      group_queue.push_back(pack_group(8'd128, 8'd128, 8'd128, 8'd128, 8'h00, 8'hFF));
      group_queue.push_back(pack_group(8'd128, 8'd128, 8'd128, 8'd128, 8'hFF, 8'h00));
      // just below and at the first nonzero level with neutral chroma
      group_queue.push_back(pack_group(8'd1, 8'd7, 8'd8, 8'd9, 8'd128, 8'd128));
      // top of range, below and at saturation
      group_queue.push_back(pack_group(8'd247, 8'd248, 8'd254, 8'd255, 8'd128, 8'd128));
      group_queue.push_back(pack_group(8'h55, 8'hAA, 8'h0F, 8'hF0, 8'h55, 8'hAA));
      group_queue.push_back(pack_group(8'hAA, 8'h55, 8'hF0, 8'h0F, 8'hAA, 8'h55));
      group_queue.push_back(pack_group(8'd100, 8'd101, 8'd102, 8'd103, 8'd127, 8'd129));
      group_queue.push_back(pack_group(8'd100, 8'd101, 8'd102, 8'd103, 8'd129, 8'd127));
      group_queue.push_back(pack_group(8'd200, 8'd210, 8'd220, 8'd230, 8'd200, 8'd60));
      group_queue.push_back(pack_group(8'd30, 8'd20, 8'd10, 8'd40, 8'd60, 8'd200));
      group_queue.push_back(pack_group(8'h01, 8'h02, 8'h04, 8'h08, 8'h01, 8'h02));
      group_queue.push_back(pack_group(8'h10, 8'h20, 8'h40, 8'h80, 8'h04, 8'h08));
      group_queue.push_back(pack_group(8'hFE, 8'hFD, 8'hFB, 8'hF7, 8'h10, 8'h20));
      group_queue.push_back(pack_group(8'hEF, 8'hDF, 8'hBF, 8'h7F, 8'h40, 8'h80));

      for (int n = 0; n < RANDOM_GROUPS; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            group_queue.push_back(REQ_DATA_W'({$urandom(), $urandom()}));
         end else if (pick < 85) begin
            group_queue.push_back(pack_group(edgy_sample(), edgy_sample(), edgy_sample(),
                                             edgy_sample(), edgy_sample(), edgy_sample()));
         end else begin
            // near-gray chroma walks luma across the clamp edges
            cb = 8'($urandom_range(120, 136));
            cr = 8'($urandom_range(120, 136));
            group_queue.push_back(pack_group(8'($urandom()), 8'($urandom()), 8'($urandom()),
                                             8'($urandom()), cb, cr));
         end
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      @(posedge clock);
      while (group_queue.size() > 0 || req_tvalid || pending_pixels.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (pending_pixels.size() > 0) begin
         fail_count++;
         $display("%0t: %0d expected words never arrived", $time, pending_pixels.size());
      end

      $display("Converted %0d 2x2 groups (extremes, clamp edges, random chroma), %0d words checked",
               accepted_groups, checked_words);
      $display("Random idling on both sides plus a %0d-cycle output hold-off; %0d errors",
               HOLD_LEN, fail_count);
      if (fail_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

>>> files.f
+incdir+rtl
rtl/ycq_pkg.sv
rtl/ycq_chroma.sv
rtl/ycq_lane.sv
rtl/ycbcr420_to_rgb5551_quad.sv
verif/ycbcr420_to_rgb5551_quad_tb.sv
